// ===== rtl/core/edmb_pkg.sv =====
package edmb_pkg;

  // store geometry and sample format
  localparam int DEPTH        = 2048;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int SLOT_W       = 2 * SAMPLE_WIDTH;
  localparam int OUT_W        = 32;
  localparam int OFFSET_W     = 16;

  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SLOT_W-1:0]              slot_t;

  // command codes
  typedef enum logic {
    CMD_TAKE  = 1'b0,
    CMD_MERGE = 1'b1
  } cmd_t;

  // write port of the sample store
  typedef struct packed {
    logic  en;
    addr_t addr;
    slot_t data;
  } wr_port_t;

  // signed halving, truncated toward zero
  function automatic sample_t half_tz(input sample_t v);
    sample_t adj;
    adj = v + sample_t'(v[SAMPLE_WIDTH-1]);
    return adj >>> 1;
  endfunction

endpackage

// ===== rtl/core/edmb_store.sv =====
module edmb_store (
  input  logic               clk,
  input  edmb_pkg::wr_port_t wr,
  input  edmb_pkg::addr_t    rd0_addr,
  input  edmb_pkg::addr_t    rd1_addr,
  output edmb_pkg::slot_t    rd0_data,
  output edmb_pkg::slot_t    rd1_data
);
  import edmb_pkg::*;

  slot_t mem [DEPTH];

  slot_t rd0_q_r;
  slot_t rd1_q_r;
  logic  fwd0_r;
  logic  fwd1_r;
  slot_t wdat_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd0_q_r <= mem[rd0_addr];
    rd1_q_r <= mem[rd1_addr];
    // read during write of the same slot returns the new data
    fwd0_r  <= wr.en && (wr.addr == rd0_addr);
    fwd1_r  <= wr.en && (wr.addr == rd1_addr);
    wdat_r  <= wr.data;
  end

  assign rd0_data = fwd0_r ? wdat_r : rd0_q_r;
  assign rd1_data = fwd1_r ? wdat_r : rd1_q_r;

endmodule

// ===== rtl/core/echo_delay_merge_buffer_core.sv =====
// result: out_valid strobes once an accepted start beat has passed the EXEC state and the out_valid register
// a new command is taken only once the last one has finished the read-modify-write
//   of one store slot (read, then merge and write back)
// reset: synchronous, active low; afterwards busy stays high while a
//   clearing pass zeroes every slot of the store
// the receiver cannot stall: each result is shown for exactly one cycle
module echo_delay_merge_buffer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_cmd,
  input  logic [edmb_pkg::OFFSET_W-1:0]         in_delay_offset,
  input  logic signed [31:0]                    in_left,
  input  logic signed [31:0]                    in_right,
  output logic                                  out_valid,
  output logic signed [edmb_pkg::OUT_W-1:0]     out_left,
  output logic signed [edmb_pkg::OUT_W-1:0]     out_right
);
  import edmb_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  addr_t   head_r, head_nxt;
  addr_t   clr_r, clr_nxt;

  // command captured at the start beat
  cmd_t    cmd_r;
  logic    in_range_r;
  addr_t   tgt_r;
  sample_t new_l_r;
  sample_t new_r_r;

  logic    out_valid_r, out_valid_nxt;
  sample_t out_l_r, out_l_nxt;
  sample_t out_r_r, out_r_nxt;

  logic    accept;
  logic    in_range;
  logic [ADDR_W:0] tgt_sum;
  addr_t   tgt;
  addr_t   rd0_addr;

  wr_port_t wr;
  slot_t    rd_tgt;
  slot_t    rd_head;

  // merge datapath
  sample_t old_l, old_r;
  sample_t head_l, head_r_smp;
  sample_t mrg_l, mrg_r;
  logic    old_nz;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // target slot: head plus offset, wrapped once; out-of-range offsets write nothing
  assign in_range = (in_delay_offset < OFFSET_W'(DEPTH));
  assign tgt_sum  = {1'b0, head_r} + {1'b0, in_delay_offset[ADDR_W-1:0]};
  always_comb begin
    if (tgt_sum >= (ADDR_W+1)'(DEPTH)) begin
      tgt = ADDR_W'(tgt_sum - (ADDR_W+1)'(DEPTH));
    end else begin
      tgt = tgt_sum[ADDR_W-1:0];
    end
  end

  // port 0 reads the target (head for a take), port 1 always reads the head
  assign rd0_addr = (cmd_t'(in_cmd) == CMD_MERGE) ? tgt : head_r;

  edmb_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd0_addr (rd0_addr),
    .rd1_addr (head_r),
    .rd0_data (rd_tgt),
    .rd1_data (rd_head)
  );

  // slot layout: right channel in the upper half
  assign old_l      = rd_tgt[SAMPLE_WIDTH-1:0];
  assign old_r      = rd_tgt[SLOT_W-1:SAMPLE_WIDTH];
  assign head_l     = rd_head[SAMPLE_WIDTH-1:0];
  assign head_r_smp = rd_head[SLOT_W-1:SAMPLE_WIDTH];
  assign old_nz     = (old_l != '0) || (old_r != '0);

  // average with the echo already in the slot, or plain store into an empty slot
  always_comb begin
    if (old_nz) begin
      mrg_l = half_tz(old_l) + half_tz(new_l_r);
      mrg_r = half_tz(old_r) + half_tz(new_r_r);
    end else begin
      mrg_l = new_l_r;
      mrg_r = new_r_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    wr            = '0;

    case (state_r)
      S_CLEAR: begin
        // zero one slot a cycle
        wr.en   = 1'b1;
        wr.addr = clr_r;
        wr.data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (cmd_r == CMD_TAKE) begin
          // hand out the head slot, clear it, step the head
          out_l_nxt = head_l;
          out_r_nxt = head_r_smp;
          wr.en     = 1'b1;
          wr.addr   = head_r;
          wr.data   = '0;
          head_nxt  = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        end else begin
          wr.en   = in_range_r;
          wr.addr = tgt_r;
          wr.data = {mrg_r, mrg_l};
          // a merge into the head reports the merged value
          if (in_range_r && (tgt_r == head_r)) begin
            out_l_nxt = mrg_l;
            out_r_nxt = mrg_r;
          end else begin
            out_l_nxt = head_l;
            out_r_nxt = head_r_smp;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= cmd_t'(in_cmd);
      in_range_r <= in_range;
      tgt_r      <= tgt;
      new_l_r    <= SAMPLE_WIDTH'(in_left);
      new_r_r    <= SAMPLE_WIDTH'(in_right);
    end
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
  end

  assign out_valid = out_valid_r;
  // cast the stored sample to the port width; both are 32 bits, so no bits are added
  assign out_left  = OUT_W'(out_l_r);
  assign out_right = OUT_W'(out_r_r);

endmodule

// ===== rtl/core/edmb_checker.sv =====
module edmb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every accepted beat yields a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  // no result without an earlier accepted beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  // the block is busy while a beat is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a beat");

  // results never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule

bind echo_delay_merge_buffer_core edmb_checker u_edmb_checker (.*);
